// ----- design/itl_pkg.sv -----
// Shared types, codes and the per-character lexing function of the IDL token lexer.
// Used by itl_step, idl_token_lexer and itl_checker; depends on nothing.
`default_nettype none

package itl_pkg;

    localparam int LINE_BITS = 24;
    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
    localparam int OUT_BITS = 8 + 3 + LINE_BITS;
    localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int MAX_RES = 7;

    localparam logic [7:0] CH_NL = 8'h0A;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_SP = 8'h20;
    localparam logic [7:0] CH_US = 8'h5F;
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_LE = 8'h65;
    localparam logic [7:0] CH_UE = 8'h45;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DQ = 8'h22;
    localparam logic [7:0] CH_SQ = 8'h27;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR = 8'h2A;

    typedef enum logic [3:0] {
        M_IDLE, M_DOC, M_COMMENT, M_LCOMMENT, M_IDENT,
        M_STR, M_STR2, M_INT, M_FLOAT, M_FLOAT2
    } mode_t;

    typedef enum logic [1:0] {R_CHAR, R_END, R_ERR, R_DONE} rkind_t;

    typedef enum logic [2:0] {T_IDENT, T_STRING, T_INT, T_FLOAT, T_DELIM, T_DOC} ttype_t;

    typedef enum logic {K_CHAR, K_EOT} ikind_t;

    typedef struct packed {
        rkind_t               kind;
        logic [7:0]           ch;
        logic [2:0]           ttype;
        logic [LINE_BITS-1:0] line;
    } res_t;

    typedef struct packed {
        mode_t                mode;
        logic [LINE_BITS-1:0] line;
        logic [LINE_BITS-1:0] tsl;
        logic                 halted;
    } lex_st_t;

    typedef struct packed {
        lex_st_t    st;
        logic       skip;
        logic [1:0] n;
        res_t [2:0] res;
    } lex_out_t;

    function automatic logic is_letter(logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_delim(logic [7:0] c);
        return c == 8'h28 || c == 8'h29 || c == 8'h3A || c == 8'h3D || c == 8'h7B ||
               c == 8'h7D || c == 8'h2C || c == 8'h3C || c == 8'h3E || c == 8'h5B ||
               c == 8'h5D || c == 8'h3B;
    endfunction

    function automatic lex_out_t put(lex_out_t o, rkind_t k, logic [7:0] c, ttype_t t,
                                     logic [LINE_BITS-1:0] ln);
        if (o.n != 2'd3) begin
            o.res[o.n].kind = k;
            o.res[o.n].ch = c;
            o.res[o.n].ttype = t;
            o.res[o.n].line = ln;
            o.n = o.n + 2'd1;
        end
        return o;
    endfunction

    function automatic lex_out_t lex_char(lex_st_t st, logic [7:0] c, logic h1,
                                          logic [7:0] c1, logic h2, logic [7:0] c2);
        lex_out_t o;
        logic again;
        o = '0;
        o.st = st;
        if (c == CH_NL && st.line != LINE_MAX) o.st.line = st.line + 1'b1;
        again = 1'b1;
        for (int p = 0; p < 2; p++) begin
            if (again) begin
                again = 1'b0;
                case (o.st.mode)
                    M_IDLE: begin
                        if (c == CH_SP || c == CH_TAB || c == CH_NL) begin
                        end else if (c == CH_SLASH && h1 && c1 == CH_STAR && h2 &&
                                     c2 == CH_STAR) begin
                            o.st.mode = M_DOC;
                            o.st.tsl = o.st.line;
                            o = put(o, R_CHAR, c, T_IDENT, '0);
                        end else if (c == CH_SLASH && h1 && c1 == CH_STAR) begin
                            o.st.mode = M_COMMENT;
                            o.st.tsl = o.st.line;
                        end else if (c == CH_SLASH && h1 && c1 == CH_SLASH) begin
                            o.st.mode = M_LCOMMENT;
                            o.st.tsl = o.st.line;
                        end else if (is_letter(c) || c == CH_US) begin
                            o.st.mode = M_IDENT;
                            o.st.tsl = o.st.line;
                            o = put(o, R_CHAR, c, T_IDENT, '0);
                        end else if (c == CH_DQ) begin
                            o.st.mode = M_STR;
                            o.st.tsl = o.st.line;
                            o = put(o, R_CHAR, CH_DQ, T_IDENT, '0);
                        end else if (c == CH_SQ) begin
                            o.st.mode = M_STR2;
                            o.st.tsl = o.st.line;
                            o = put(o, R_CHAR, CH_DQ, T_IDENT, '0);
                        end else if (is_delim(c)) begin
                            o = put(o, R_CHAR, c, T_IDENT, '0);
                            o = put(o, R_END, 8'h00, T_DELIM, o.st.line);
                        end else if (is_digit(c) || c == CH_PLUS || c == CH_MINUS) begin
                            o.st.mode = M_INT;
                            o.st.tsl = o.st.line;
                            o = put(o, R_CHAR, c, T_IDENT, '0);
                        end else if (c == CH_DOT) begin
                            o.st.mode = M_FLOAT;
                            o.st.tsl = o.st.line;
                            o = put(o, R_CHAR, c, T_IDENT, '0);
                        end else begin
                            o = put(o, R_ERR, c, T_IDENT, o.st.line);
                            o.st.halted = 1'b1;
                        end
                    end
                    M_DOC: begin
                        o = put(o, R_CHAR, c, T_IDENT, '0);
                        if (c == CH_STAR && h1 && c1 == CH_SLASH) begin
                            o = put(o, R_CHAR, CH_SLASH, T_IDENT, '0);
                            o = put(o, R_END, 8'h00, T_DOC, o.st.tsl);
                            o.st.mode = M_IDLE;
                            o.skip = 1'b1;
                        end
                    end
                    M_COMMENT: begin
                        if (c == CH_STAR && h1 && c1 == CH_SLASH) begin
                            o.st.mode = M_IDLE;
                            o.skip = 1'b1;
                        end
                    end
                    M_LCOMMENT: begin
                        if (c == CH_NL) o.st.mode = M_IDLE;
                    end
                    M_IDENT: begin
                        if (!is_letter(c) && !is_digit(c) && c != CH_US && c != CH_DOT) begin
                            o = put(o, R_END, 8'h00, T_IDENT, o.st.tsl);
                            o.st.mode = M_IDLE;
                            again = 1'b1;
                        end else begin
                            o = put(o, R_CHAR, c, T_IDENT, '0);
                        end
                    end
                    M_STR, M_STR2: begin
                        if ((o.st.mode == M_STR && c == CH_DQ) ||
                            (o.st.mode == M_STR2 && c == CH_SQ)) begin
                            o = put(o, R_CHAR, CH_DQ, T_IDENT, '0);
                            o = put(o, R_END, 8'h00, T_STRING, o.st.tsl);
                            o.st.mode = M_IDLE;
                        end else begin
                            o = put(o, R_CHAR, c, T_IDENT, '0);
                        end
                    end
                    M_INT: begin
                        if (is_digit(c)) begin
                            o = put(o, R_CHAR, c, T_IDENT, '0);
                        end else if (c == CH_DOT) begin
                            o.st.mode = M_IDLE;
                            again = 1'b1;
                        end else if (c == CH_LE || c == CH_UE) begin
                            o.st.mode = M_FLOAT;
                            again = 1'b1;
                        end else begin
                            o = put(o, R_END, 8'h00, T_INT, o.st.tsl);
                            o.st.mode = M_IDLE;
                            again = 1'b1;
                        end
                    end
                    M_FLOAT: begin
                        if (is_digit(c)) begin
                            o = put(o, R_CHAR, c, T_IDENT, '0);
                        end else if (c == CH_LE || c == CH_UE) begin
                            o = put(o, R_CHAR, c, T_IDENT, '0);
                            o.st.mode = M_FLOAT2;
                            if (h1 && (c1 == CH_PLUS || c1 == CH_MINUS)) begin
                                o = put(o, R_CHAR, c1, T_IDENT, '0);
                                o.skip = 1'b1;
                            end
                        end else begin
                            o = put(o, R_END, 8'h00, T_FLOAT, o.st.tsl);
                            o.st.mode = M_IDLE;
                            again = 1'b1;
                        end
                    end
                    M_FLOAT2: begin
                        if (is_digit(c)) begin
                            o = put(o, R_CHAR, c, T_IDENT, '0);
                        end else begin
                            o = put(o, R_END, 8'h00, T_FLOAT, o.st.tsl);
                            o.st.mode = M_IDLE;
                            again = 1'b1;
                        end
                    end
                    default: begin
                        o.st.mode = M_IDLE;
                        again = 1'b1;
                    end
                endcase
            end
        end
        return o;
    endfunction

endpackage

`default_nettype wire

// ----- design/itl_step.sv -----
// One request of the lexer: window update, lexing and the list of results it causes.
// Pure combinational; depends on itl_pkg.
`default_nettype none

module itl_step
    import itl_pkg::*;
(
    input  wire ikind_t     kind,
    input  wire [7:0]       ch,
    input  wire lex_st_t    st,
    input  wire [7:0]       la0,
    input  wire [7:0]       la1,
    input  wire [1:0]       la_cnt,
    output lex_st_t         st_next,
    output logic [7:0]      la0_next,
    output logic [7:0]      la1_next,
    output logic [1:0]      la_cnt_next,
    output res_t [MAX_RES-1:0] list,
    output logic [2:0]      n
);

    lex_out_t a;
    lex_out_t b;
    logic     two;

    always_comb begin
        two = (la_cnt == 2'd2);
        a = lex_char(st, la0, 1'b1, la1, 1'b1, ch);
        b = lex_char(st, la0, two, la1, 1'b0, 8'h00);
        st_next = st;
        la0_next = la0;
        la1_next = la1;
        la_cnt_next = la_cnt;
        list = '0;
        n = 3'd0;
        if (kind == K_CHAR) begin
            if (!st.halted) begin
                if (la_cnt != 2'd2) begin
                    if (la_cnt[0]) la1_next = ch;
                    else la0_next = ch;
                    la_cnt_next = la_cnt + 2'd1;
                end else begin
                    st_next = a.st;
                    for (int i = 0; i < 3; i++) begin
                        if (2'(i) < a.n) begin
                            list[n] = a.res[i];
                            n = n + 3'd1;
                        end
                    end
                    if (!a.skip) begin
                        la0_next = la1;
                        la1_next = ch;
                        la_cnt_next = 2'd2;
                    end else begin
                        la0_next = ch;
                        la1_next = 8'h00;
                        la_cnt_next = 2'd1;
                    end
                end
            end
        end else begin
            if (!st.halted && la_cnt != 2'd0) begin
                st_next = b.st;
                for (int i = 0; i < 3; i++) begin
                    if (2'(i) < b.n) begin
                        list[n] = b.res[i];
                        n = n + 3'd1;
                    end
                end
                if (two && !b.skip && !b.st.halted) begin
                    a = lex_char(b.st, la1, 1'b0, 8'h00, 1'b0, 8'h00);
                    st_next = a.st;
                    for (int i = 0; i < 3; i++) begin
                        if (2'(i) < a.n) begin
                            list[n] = a.res[i];
                            n = n + 3'd1;
                        end
                    end
                end
            end
            list[n] = '{kind: R_DONE, ch: 8'h00, ttype: 3'd0, line: st_next.line};
            n = n + 3'd1;
            st_next = '{mode: M_IDLE, line: LINE_BITS'(1), tsl: '0, halted: 1'b0};
            la0_next = 8'h00;
            la1_next = 8'h00;
            la_cnt_next = 2'd0;
        end
    end

endmodule

`default_nettype wire

// ----- design/idl_token_lexer.sv -----
// Top level of the IDL token lexer: input register, lexer state, result buffer.
// Depends on itl_pkg and itl_step.
//
//   channel | dir | tdata                               | tuser        | tlast
//   s_      | in  | char_in[7:0]                        | kind         | -
//   m_      | out | char_out, token_type, line (low up) | result_kind  | last_of_run
//
// A request is lexed combinationally once it sits in the input register and the buffer is empty
// or giving up its last result; its first result is offered on the next cycle.
// Its results leave one a cycle while m_tready is high.
// A request may have no result; up to seven results follow end of text.
// m_tready low holds the buffer and, once the input register is full, s_tready.
// aresetn is synchronous; it clears the lexer state and the valid flags of the input register and buffer.
`default_nettype none

module idl_token_lexer
    import itl_pkg::*;
(
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              s_tvalid,
    output logic             s_tready,
    input  wire [7:0]        s_tdata,   // char_in[7:0]
    input  wire [0:0]        s_tuser,   // kind[0]
    output logic             m_tvalid,
    input  wire              m_tready,
    output logic [OUT_W-1:0] m_tdata,   // char_out[7:0], token_type[10:8], line[34:11]
    output logic [1:0]       m_tuser,   // result_kind[1:0]
    output logic             m_tlast
);

    logic               in_vld_reg;
    ikind_t             in_kind_reg;
    logic [7:0]         in_ch_reg;
    lex_st_t            st_reg;
    lex_st_t            st_next;
    logic [7:0]         la0_reg, la0_next;
    logic [7:0]         la1_reg, la1_next;
    logic [1:0]         la_cnt_reg, la_cnt_next;
    res_t [MAX_RES-1:0] buf_reg;
    res_t [MAX_RES-1:0] list;
    logic [2:0]         n;
    logic [2:0]         cnt_reg;
    logic [2:0]         idx_reg;
    logic               out_last;
    logic               out_take;
    logic               fire;
    res_t               cur;

    itl_step u_step (
        .kind        (in_kind_reg),
        .ch          (in_ch_reg),
        .st          (st_reg),
        .la0         (la0_reg),
        .la1         (la1_reg),
        .la_cnt      (la_cnt_reg),
        .st_next     (st_next),
        .la0_next    (la0_next),
        .la1_next    (la1_next),
        .la_cnt_next (la_cnt_next),
        .list        (list),
        .n           (n)
    );

    assign cur      = buf_reg[idx_reg];
    assign out_last = (idx_reg == cnt_reg - 3'd1);
    assign out_take = m_tvalid && m_tready;
    assign fire     = in_vld_reg && (cnt_reg == 3'd0 || (out_take && out_last));
    assign s_tready = !in_vld_reg || fire;

    assign m_tvalid = (cnt_reg != 3'd0);
    assign m_tuser  = cur.kind;
    assign m_tlast  = out_last;
    assign m_tdata  = OUT_W'({cur.line, cur.ttype, cur.ch});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            st_reg     <= '{mode: M_IDLE, line: LINE_BITS'(1), tsl: '0, halted: 1'b0};
            la0_reg    <= 8'h00;
            la1_reg    <= 8'h00;
            la_cnt_reg <= 2'd0;
            cnt_reg    <= 3'd0;
            idx_reg    <= 3'd0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_vld_reg  <= 1'b1;
                in_kind_reg <= ikind_t'(s_tuser[0]);
                in_ch_reg   <= s_tdata;
            end else if (fire) begin
                in_vld_reg <= 1'b0;
            end
            if (fire) begin
                st_reg     <= st_next;
                la0_reg    <= la0_next;
                la1_reg    <= la1_next;
                la_cnt_reg <= la_cnt_next;
                buf_reg    <= list;
                cnt_reg    <= n;
                idx_reg    <= 3'd0;
            end else if (out_take) begin
                if (out_last) cnt_reg <= 3'd0;
                else idx_reg <= idx_reg + 3'd1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/itl_checker.sv -----
// Port-level checks of the IDL token lexer, bound to the top level.
// Depends on itl_pkg.
`default_nettype none

module itl_checker
    import itl_pkg::*;
(
    input wire             aclk,
    input wire             aresetn,
    input wire             m_tvalid,
    input wire             m_tready,
    input wire [OUT_W-1:0] m_tdata,
    input wire [1:0]       m_tuser,
    input wire             m_tlast
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == R_DONE |-> m_tlast)
        else $error("end of text not last of request");

    a_char_no_line: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == R_CHAR || m_tuser == R_ERR) |-> m_tdata[10:8] == 3'd0)
        else $error("token type on character result");

    a_end_no_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == R_END |-> m_tdata[7:0] == 8'h00)
        else $error("character on token end");

endmodule

bind idl_token_lexer itl_checker u_itl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
